// ===== hw/rtl/stream_pattern_replace_unit_assert.svh =====
// Assertion macros used by the back end of the stream pattern replace unit
`ifndef STREAM_PATTERN_REPLACE_UNIT_ASSERT_SVH
`define STREAM_PATTERN_REPLACE_UNIT_ASSERT_SVH

// check a condition at every rising clock edge outside reset
`define SPR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("stream pattern replace: check failed");

// check that a condition implies another in the same cycle
`define SPR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stream pattern replace: implication failed");

`endif

// ===== hw/rtl/spr_pkg.sv =====
// Shared types and constants of the stream pattern replace unit
package spr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int PAT_W       = PATTERN_MAX * BYTE_W;
  localparam int REP_W       = REPLACE_MAX * BYTE_W;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_present;
    logic              last_of_text;
  } out_item_t;

  typedef struct packed {
    logic [PAT_W-1:0] pat_bytes;
    logic [LEN_W-1:0] pat_len;
    logic [REP_W-1:0] rep_bytes;
    logic [LEN_W-1:0] rep_len;
  } spr_cfg_t;

endpackage

// ===== hw/rtl/spr_front.sv =====
// Front end: accepts text items into a two-entry queue for the scan engine
module spr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  spr_pkg::in_item_t item_i,
  output logic              full_o,
  output logic              head_valid_o,
  output spr_pkg::in_item_t head_o,
  input  logic              pop_i
);
  import spr_pkg::*;

  in_item_t   mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== hw/rtl/spr_back.sv =====
// Back end: scan engine that matches held bytes and emits result items
`include "stream_pattern_replace_unit_assert.svh"

module spr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spr_pkg::spr_cfg_t  cfg_i,
  input  logic               held_clr_i,
  input  logic               item_valid_i,
  input  spr_pkg::in_item_t  item_i,
  output logic               item_pop_o,
  output logic               out_valid_o,
  output spr_pkg::out_item_t out_item_o,
  input  logic               out_pop_i
);
  import spr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_REPL = 3'b100
  } spr_state_e;

  spr_state_e        state_q, state_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic [PAT_W-1:0]  work_q, work_d;
  logic              end_q, end_d;
  logic [2:0]        k_q, k_d;
  logic              hold_v_q, hold_v_d;
  logic [BYTE_W-1:0] hold_byte_q, hold_byte_d;
  logic              out_v_q, out_v_d;
  out_item_t         out_q, out_d;

  logic [PATTERN_MAX-1:0] eq, mask_p, mask_n;
  logic                   full_match, part_match;
  logic                   can_push, emit_ok, fin_ok;
  logic                   do_emit;
  logic [BYTE_W-1:0]      emit_byte;
  logic [PAT_W-1:0]       work_shift_p;
  logic [LEN_W-1:0]       n_minus_p;
  logic                   repl_last;

  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      eq[k]     = (work_q[k*BYTE_W +: BYTE_W] == cfg_i.pat_bytes[k*BYTE_W +: BYTE_W]);
      mask_p[k] = (LEN_W'(k) < cfg_i.pat_len);
      mask_n[k] = (LEN_W'(k) < n_q);
    end
  end

  assign full_match   = (cfg_i.pat_len != '0) && (n_q >= cfg_i.pat_len) && (&(eq | ~mask_p));
  assign part_match   = !end_q && (cfg_i.pat_len != '0) && (n_q < cfg_i.pat_len)
                        && (&(eq | ~mask_n));
  assign can_push     = !out_v_q || out_pop_i;
  assign emit_ok      = !hold_v_q || can_push;
  assign fin_ok       = end_q ? can_push : emit_ok;
  assign work_shift_p = work_q >> {cfg_i.pat_len, 3'b000};
  assign n_minus_p    = n_q - cfg_i.pat_len;
  assign repl_last    = ({1'b0, k_q} + LEN_W'(1)) == cfg_i.rep_len;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    work_d      = work_q;
    end_d       = end_q;
    k_d         = k_q;
    hold_v_d    = hold_v_q;
    hold_byte_d = hold_byte_q;
    out_v_d     = out_v_q && !out_pop_i;
    out_d       = out_q;
    item_pop_o  = 1'b0;
    do_emit     = 1'b0;
    emit_byte   = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          work_d[n_q[2:0]*BYTE_W +: BYTE_W] = item_i.data_byte;
          n_d     = n_q + LEN_W'(1);
          end_d   = item_i.end_of_text;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (n_q == '0 || part_match) begin
          if (fin_ok) begin
            if (end_q || hold_v_q) begin
              out_v_d = 1'b1;
              out_d   = '{out_byte: hold_v_q ? hold_byte_q : '0,
                          byte_present: hold_v_q,
                          last_of_text: end_q};
            end
            hold_v_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end else if (full_match) begin
          if (cfg_i.rep_len == '0) begin
            work_d = work_shift_p;
            n_d    = n_minus_p;
          end else if (emit_ok) begin
            do_emit   = 1'b1;
            emit_byte = cfg_i.rep_bytes[BYTE_W-1:0];
            if (cfg_i.rep_len == LEN_W'(1)) begin
              work_d = work_shift_p;
              n_d    = n_minus_p;
            end else begin
              k_d     = 3'd1;
              state_d = ST_REPL;
            end
          end
        end else begin
          if (emit_ok) begin
            do_emit   = 1'b1;
            emit_byte = work_q[BYTE_W-1:0];
            work_d    = work_q >> BYTE_W;
            n_d       = n_q - LEN_W'(1);
          end
        end
      end
      ST_REPL: begin
        if (emit_ok) begin
          do_emit   = 1'b1;
          emit_byte = cfg_i.rep_bytes[k_q*BYTE_W +: BYTE_W];
          if (repl_last) begin
            work_d  = work_shift_p;
            n_d     = n_minus_p;
            state_d = ST_SCAN;
          end else begin
            k_d = k_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_emit) begin
      if (hold_v_q) begin
        out_v_d = 1'b1;
        out_d   = '{out_byte: hold_byte_q, byte_present: 1'b1, last_of_text: 1'b0};
      end
      hold_byte_d = emit_byte;
      hold_v_d    = 1'b1;
    end

    if (held_clr_i) begin
      n_d = '0;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n_q      <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q      <= work_d;
    end_q       <= end_d;
    k_q         <= k_d;
    hold_byte_q <= hold_byte_d;
    out_q       <= out_d;
  end

  `SPR_ASSERT(a_held_bound, n_q <= LEN_W'(PATTERN_MAX))
  `SPR_ASSERT_IMPL(a_idle_room, state_q == ST_IDLE, n_q < LEN_W'(PATTERN_MAX))
  `SPR_ASSERT_IMPL(a_hold_flushed, hold_v_q, state_q != ST_IDLE)
  `SPR_ASSERT_IMPL(a_repl_from_scan, state_q == ST_REPL, $past(state_q) != ST_IDLE)

endmodule

// ===== hw/rtl/stream_pattern_replace_unit.sv =====
// Top level of the stream pattern replace unit: configuration registers and block wiring
//
// Streams text one byte per item and replaces every leftmost non-overlapping
// occurrence of the configured pattern (up to 8 bytes) by the configured
// replacement (0 to 8 bytes); a pattern length of 0 passes text through.
// Bytes that may still start a match are held until decided, and the end mark
// of a text flushes them; the final result carries last_of_text, and a text
// whose tail was deleted ends with one result that has no byte. Items enter a
// two-entry queue; a single scan engine takes one item at a time: it loads the
// item, emits bytes one by one, drops each match whose replacement is empty,
// and closes the item; it stalls while results are not popped.
// Writing pattern_length drops held bytes. Write configuration only while idle.
module stream_pattern_replace_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  input  spr_pkg::in_item_t                    in_item_i,
  output logic                                 full,
  output logic                                 empty,
  output spr_pkg::out_item_t                   out_item_o,
  input  logic                                 pop,
  input  logic                                 cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [spr_pkg::CFG_W-1:0]            cfg_wdata_i
);
  import spr_pkg::*;

  logic [PAT_W-1:0] pat_bytes_q;
  logic [LEN_W-1:0] pat_len_q;
  logic [REP_W-1:0] rep_bytes_q;
  logic [LEN_W-1:0] rep_len_q;
  logic             held_clr;
  spr_cfg_t         cfg;
  logic             head_valid;
  in_item_t         head;
  logic             head_pop;
  logic             out_valid;

  assign held_clr = cfg_we_i && (cfg_idx_i == REG_PATTERN_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= '0;
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PATTERN_BYTES:      pat_bytes_q <= cfg_wdata_i[PAT_W-1:0];
        REG_PATTERN_LENGTH:     pat_len_q   <= cfg_wdata_i[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  rep_bytes_q <= cfg_wdata_i[REP_W-1:0];
        REG_REPLACEMENT_LENGTH: rep_len_q   <= cfg_wdata_i[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.pat_bytes = pat_bytes_q;
    cfg.pat_len   = (pat_len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_q;
    cfg.rep_bytes = rep_bytes_q;
    cfg.rep_len   = (rep_len_q > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rep_len_q;
  end

  spr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (in_item_i),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (head_pop)
  );

  spr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .held_clr_i   (held_clr),
    .item_valid_i (head_valid),
    .item_i       (head),
    .item_pop_o   (head_pop),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item_o),
    .out_pop_i    (pop)
  );

  assign empty = !out_valid;

endmodule
